### hdl/bf_pkg.sv
// Shared types and constants for the Blowfish engine.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package bf_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  sbox_addr_t;

  // Table geometry
  localparam int P_WORDS     = 18;
  localparam int S_WORDS     = 1024;
  localparam int S_BOXES     = 4;
  localparam int P_IDX_W     = 5;
  localparam int S_LIN_W     = 10;

  // Byte extraction mask for key loads
  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  // Register file
  localparam logic [5:0] KEY_LENGTH_RESET = 6'd56;
  localparam logic       REG_KEY_LENGTH   = 1'b0;
  localparam logic       REG_CHAIN_MODE   = 1'b1;

  // Request codes
  typedef enum logic [2:0] {
    REQ_LOAD_WORD = 3'd0,
    REQ_LOAD_KEY  = 3'd1,
    REQ_EXPAND    = 3'd2,
    REQ_ENCRYPT   = 3'd3,
    REQ_DECRYPT   = 3'd4
  } req_code_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_ADDR,
    ST_KEY_DATA,
    ST_RND_A,
    ST_RND_B,
    ST_FIN_R,
    ST_FIN_L,
    ST_DELIVER,
    ST_FILL_LO,
    ST_FILL_HI
  } state_t;

endpackage

### hdl/bf_req_if.sv
// Request channel of the Blowfish engine: valid/ready plus request payload.
// Depends on bf_pkg for the word type.
interface bf_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [10:0]       index;
  bf_pkg::word_t     word_left;
  bf_pkg::word_t     word_right;
  logic              first_block;

  modport source (output valid, req_type, index, word_left, word_right, first_block,
                  input ready);
  modport sink   (input valid, req_type, index, word_left, word_right, first_block,
                  output ready);
endinterface

### hdl/bf_res_if.sv
// Result channel of the Blowfish engine: valid/ready plus one 64-bit block.
// Depends on bf_pkg for the word type.
interface bf_res_if;
  logic          valid;
  logic          ready;
  bf_pkg::word_t result_left;
  bf_pkg::word_t result_right;

  modport source (output valid, result_left, result_right, input ready);
  modport sink   (input valid, result_left, result_right, output ready);
endinterface

### hdl/blowfish_block_cipher.sv
// Top level of the Blowfish engine: sequencer, P array, key store, chaining, APB registers.
// Depends on bf_pkg, bf_req_if, bf_res_if, bf_sbox_ram and bf_feistel.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-----------------------------------------------
//  req      | in        | valid / ready     | req_type, index, word_left, word_right,
//           |           |                   | first_block
//  res      | out       | valid / ready     | result_left, result_right
//  apb      | in        | psel/penable      | paddr, pwdata, prdata (pready tied high)
//
// Encrypt and decrypt use one shared Feistel unit: each round is a P fetch and S-box read
// step, then an F mix step, and two output whitening steps follow the last round. Loads
// are written on acceptance and leave the sequencer idle. Key expansion mixes the key into
// P one key byte at a time from the key memory, then runs (ROUNDS+3)/2+512 encipherments.
// Reset (rst, synchronous) clears the sequencer, the result valid and chaining, and resets registers.
// The block takes one request at a time; a finished result waits in the output register
// while the next request is accepted, and only a second result stalls on it.
module blowfish_block_cipher #(
  parameter int ROUNDS        = 16,
  parameter int MAX_KEY_BYTES = 56
) (
  input  logic        clk,
  input  logic        rst,
  bf_req_if.sink      req,
  bf_res_if.source    res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW    = bf_pkg::P_IDX_W;
  localparam int KW    = $clog2(MAX_KEY_BYTES);
  localparam int RW    = $clog2(ROUNDS);
  localparam int NP    = (ROUNDS + 3) / 2;
  localparam int FILLS = NP + bf_pkg::S_WORDS / 2;
  localparam int FW    = $clog2(FILLS);

  bf_pkg::state_t state, state_next;

  // Datapath registers
  bf_pkg::word_t  xl, xr;
  logic [RW-1:0]  rnd;
  logic           dec;
  logic           expanding;
  logic [63:0]    mask;
  logic [63:0]    chain_prev;
  logic [23:0]    acc;
  logic [1:0]     byte_cnt;
  logic [PW-1:0]  widx;
  logic [FW-1:0]  fill_cnt;
  logic [KW-1:0]  key_ptr;
  logic [7:0]     key_q;

  // Configuration registers
  logic [5:0]     key_length;
  logic           chain_mode;

  // Stores
  bf_pkg::word_t  p_mem [bf_pkg::P_WORDS];
  logic [7:0]     key_mem [MAX_KEY_BYTES];

  // Combinational controls
  logic                  accept;
  logic                  out_free;
  logic                  is_p, is_s;
  logic [bf_pkg::S_LIN_W-1:0] s_lin;
  logic [PW-1:0]         p_rd_idx;
  bf_pkg::word_t         p_rd;
  logic                  p_we;
  logic [PW-1:0]         p_widx;
  bf_pkg::word_t         p_wdata;
  logic [bf_pkg::S_BOXES-1:0] s_we;
  bf_pkg::sbox_addr_t    s_waddr;
  bf_pkg::word_t         s_wdata;
  bf_pkg::sbox_addr_t    s_raddr [bf_pkg::S_BOXES];
  bf_pkg::word_t         s_rdata [bf_pkg::S_BOXES];
  bf_pkg::word_t         xl_mix;
  bf_pkg::word_t         xr_round;
  logic [PW-1:0]         p_round_idx;
  logic [7:0]            eff_len;
  logic [KW-1:0]         key_ptr_next;
  bf_pkg::word_t         acc_next;
  logic                  fill_p;
  logic [8:0]            pair;
  logic [PW-1:0]         p_even, p_odd;
  logic [63:0]           chain_mask;
  logic                  cfg_wr;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == bf_pkg::ST_IDLE);
  assign out_free = !res.valid || res.ready;

  // Table load decode
  assign is_p  = req.index < 11'(bf_pkg::P_WORDS);
  assign is_s  = !is_p && (req.index < 11'(bf_pkg::P_WORDS + bf_pkg::S_WORDS));
  assign s_lin = bf_pkg::S_LIN_W'(req.index - 11'(bf_pkg::P_WORDS));

  // Fill target decode
  assign fill_p = fill_cnt < FW'(NP);
  assign pair   = 9'(fill_cnt - FW'(NP));
  assign p_even = {fill_cnt[PW-2:0], 1'b0};
  assign p_odd  = {fill_cnt[PW-2:0], 1'b1};

  // Round P index: forward for encipher, reversed for decipher
  assign p_round_idx = dec ? (PW'(ROUNDS + 1) - PW'(rnd)) : PW'(rnd);

  assign p_rd   = p_mem[p_rd_idx];
  assign xl_mix = xl ^ p_rd;

  // Effective key length: zero acts as one, saturate at the store depth
  always_comb begin
    if (key_length == 6'd0) begin
      eff_len = 8'd1;
    end else if (8'(key_length) > 8'(MAX_KEY_BYTES)) begin
      eff_len = 8'(MAX_KEY_BYTES);
    end else begin
      eff_len = 8'(key_length);
    end
  end

  assign key_ptr_next = ((8'(key_ptr) + 8'd1) >= eff_len) ? '0 : key_ptr + KW'(1);
  assign acc_next     = {acc, key_q};

  assign chain_mask = (chain_mode && !req.first_block) ? chain_prev : 64'd0;

  // S-box memories and the shared Feistel unit
  for (genvar b = 0; b < bf_pkg::S_BOXES; b++) begin : g_sbox
    assign s_raddr[b] = xl_mix[31 - 8*b -: 8];
    bf_sbox_ram u_ram (
      .clk   (clk),
      .we    (s_we[b]),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr[b]),
      .rdata (s_rdata[b])
    );
  end

  bf_feistel u_feistel (
    .s_data   (s_rdata),
    .xr       (xr),
    .xr_mixed (xr_round)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, P/S write ports and P read select
  always_comb begin
    state_next = state;
    p_rd_idx   = p_round_idx;
    p_we       = 1'b0;
    p_widx     = widx;
    p_wdata    = xl;
    s_we       = '0;
    s_waddr    = {pair[6:0], 1'b0};
    s_wdata    = xl;
    case (state)
      bf_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            bf_pkg::REQ_LOAD_WORD: begin
              if (is_p) begin
                p_we    = 1'b1;
                p_widx  = req.index[PW-1:0];
                p_wdata = req.word_left;
              end else if (is_s) begin
                s_we[s_lin[9:8]] = 1'b1;
                s_waddr          = s_lin[7:0];
                s_wdata          = req.word_left;
              end
            end
            bf_pkg::REQ_EXPAND:  state_next = bf_pkg::ST_KEY_ADDR;
            bf_pkg::REQ_ENCRYPT: state_next = bf_pkg::ST_RND_A;
            bf_pkg::REQ_DECRYPT: state_next = bf_pkg::ST_RND_A;
            default:             state_next = bf_pkg::ST_IDLE;
          endcase
        end
      end
      bf_pkg::ST_KEY_ADDR: begin
        state_next = bf_pkg::ST_KEY_DATA;
      end
      bf_pkg::ST_KEY_DATA: begin
        p_rd_idx   = widx;
        state_next = bf_pkg::ST_KEY_ADDR;
        if (byte_cnt == 2'd3) begin
          p_we    = 1'b1;
          p_widx  = widx;
          p_wdata = p_rd ^ acc_next;
          if (widx == PW'(ROUNDS + 1)) begin
            state_next = bf_pkg::ST_RND_A;
          end
        end
      end
      bf_pkg::ST_RND_A: begin
        state_next = bf_pkg::ST_RND_B;
      end
      bf_pkg::ST_RND_B: begin
        state_next = (rnd == RW'(ROUNDS - 1)) ? bf_pkg::ST_FIN_R : bf_pkg::ST_RND_A;
      end
      bf_pkg::ST_FIN_R: begin
        p_rd_idx   = dec ? PW'(1) : PW'(ROUNDS);
        state_next = bf_pkg::ST_FIN_L;
      end
      bf_pkg::ST_FIN_L: begin
        p_rd_idx   = dec ? PW'(0) : PW'(ROUNDS + 1);
        state_next = expanding ? bf_pkg::ST_FILL_LO : bf_pkg::ST_DELIVER;
      end
      bf_pkg::ST_DELIVER: begin
        if (out_free) begin
          state_next = bf_pkg::ST_IDLE;
        end
      end
      bf_pkg::ST_FILL_LO: begin
        if (fill_p) begin
          p_we    = 1'b1;
          p_widx  = p_even;
          p_wdata = xl;
        end else begin
          s_we[pair[8:7]] = 1'b1;
          s_waddr         = {pair[6:0], 1'b0};
          s_wdata         = xl;
        end
        state_next = bf_pkg::ST_FILL_HI;
      end
      bf_pkg::ST_FILL_HI: begin
        if (fill_p) begin
          p_we    = p_odd < PW'(bf_pkg::P_WORDS);
          p_widx  = p_odd;
          p_wdata = xr;
        end else begin
          s_we[pair[8:7]] = 1'b1;
          s_waddr         = {pair[6:0], 1'b1};
          s_wdata         = xr;
        end
        state_next = (fill_cnt == FW'(FILLS - 1)) ? bf_pkg::ST_IDLE : bf_pkg::ST_RND_A;
      end
      default: state_next = bf_pkg::ST_IDLE;
    endcase
  end

  // P array write port
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_widx] <= p_wdata;
    end
  end

  // Key store: write on key load, registered read at the running key pointer
  always_ff @(posedge clk) begin
    if (accept && req.req_type == bf_pkg::REQ_LOAD_KEY &&
        req.index < 11'(MAX_KEY_BYTES)) begin
      key_mem[req.index[KW-1:0]] <= 8'(req.word_left & 32'(bf_pkg::BYTE_MASK));
    end
    key_q <= key_mem[key_ptr];
  end

  // Datapath: block halves, round counter, key mixing and fill counters
  always_ff @(posedge clk) begin
    case (state)
      bf_pkg::ST_IDLE: begin
        if (accept) begin
          dec      <= (req.req_type == bf_pkg::REQ_DECRYPT);
          rnd      <= '0;
          widx     <= '0;
          byte_cnt <= '0;
          key_ptr  <= '0;
          mask     <= (req.req_type == bf_pkg::REQ_DECRYPT) ? chain_mask : 64'd0;
          if (req.req_type == bf_pkg::REQ_ENCRYPT) begin
            xl <= req.word_left  ^ chain_mask[63:32];
            xr <= req.word_right ^ chain_mask[31:0];
          end else begin
            xl <= req.word_left;
            xr <= req.word_right;
          end
        end
      end
      bf_pkg::ST_KEY_DATA: begin
        acc      <= acc_next[23:0];
        byte_cnt <= byte_cnt + 2'd1;
        key_ptr  <= key_ptr_next;
        if (byte_cnt == 2'd3) begin
          widx <= widx + PW'(1);
          if (widx == PW'(ROUNDS + 1)) begin
            xl       <= '0;
            xr       <= '0;
            rnd      <= '0;
            dec      <= 1'b0;
            fill_cnt <= '0;
          end
        end
      end
      bf_pkg::ST_RND_A: begin
        xl <= xl_mix;
      end
      bf_pkg::ST_RND_B: begin
        xl  <= xr_round;
        xr  <= xl;
        rnd <= rnd + RW'(1);
      end
      bf_pkg::ST_FIN_R: begin
        xl <= xl ^ p_rd;
      end
      bf_pkg::ST_FIN_L: begin
        xl <= xr ^ p_rd;
        xr <= xl;
      end
      bf_pkg::ST_FILL_HI: begin
        fill_cnt <= fill_cnt + FW'(1);
        rnd      <= '0;
      end
      default: begin
      end
    endcase
  end

  // Expansion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      expanding <= 1'b0;
    end else if (accept) begin
      expanding <= (req.req_type == bf_pkg::REQ_EXPAND);
    end else if (state == bf_pkg::ST_FILL_HI && fill_cnt == FW'(FILLS - 1)) begin
      expanding <= 1'b0;
    end
  end

  // Chaining value: decrypt keeps its input, encrypt keeps its output
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_prev <= 64'd0;
    end else if (accept && req.req_type == bf_pkg::REQ_DECRYPT) begin
      chain_prev <= {req.word_left, req.word_right};
    end else if (state == bf_pkg::ST_DELIVER && out_free && !dec) begin
      chain_prev <= {xl, xr};
    end
  end

  // Output register: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == bf_pkg::ST_DELIVER && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bf_pkg::ST_DELIVER && out_free) begin
      res.result_left  <= xl ^ mask[63:32];
      res.result_right <= xr ^ mask[31:0];
    end
  end

  // APB register file
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= bf_pkg::KEY_LENGTH_RESET;
      chain_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        bf_pkg::REG_KEY_LENGTH: key_length <= pwdata[5:0];
        bf_pkg::REG_CHAIN_MODE: chain_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bf_pkg::REG_KEY_LENGTH: prdata = {26'd0, key_length};
      bf_pkg::REG_CHAIN_MODE: prdata = {31'd0, chain_mode};
      default:                prdata = 32'd0;
    endcase
  end

  // A new result appears only out of the delivery step
  a_valid_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == bf_pkg::ST_DELIVER)
    else $error("result valid raised outside delivery");

  // The mix half of a round always follows its fetch half
  a_round_order: assert property (@(posedge clk) disable iff (rst)
    state == bf_pkg::ST_RND_B |-> $past(state) == bf_pkg::ST_RND_A)
    else $error("round mix without fetch");

  // Key expansion never drives the result channel
  a_no_deliver_in_expand: assert property (@(posedge clk) disable iff (rst)
    state == bf_pkg::ST_DELIVER |-> !expanding)
    else $error("delivery during key expansion");

  // Round counter stays within the round count while rounds run
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bf_pkg::ST_RND_A || state == bf_pkg::ST_RND_B) |-> rnd <= RW'(ROUNDS - 1))
    else $error("round counter out of range");

  // Fill counter stays within the table refill
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bf_pkg::ST_FILL_LO || state == bf_pkg::ST_FILL_HI) |->
      (expanding && fill_cnt <= FW'(FILLS - 1)))
    else $error("fill counter out of range");

endmodule

### hdl/bf_sbox_ram.sv
// One 256 x 32 S-box memory: one write port, one read port, registered read data.
// Depends on bf_pkg for word and address types.
module bf_sbox_ram (
  input  logic                clk,
  input  logic                we,
  input  bf_pkg::sbox_addr_t  waddr,
  input  bf_pkg::word_t       wdata,
  input  bf_pkg::sbox_addr_t  raddr,
  output bf_pkg::word_t       rdata
);

  bf_pkg::word_t mem [256];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/bf_feistel.sv
// Feistel half-round: combine the four S-box words and fold them into the right half.
// Depends on bf_pkg for the word type and the S-box count.
module bf_feistel (
  input  bf_pkg::word_t s_data [bf_pkg::S_BOXES],
  input  bf_pkg::word_t xr,
  output bf_pkg::word_t xr_mixed
);

  bf_pkg::word_t sum01;
  bf_pkg::word_t f_out;

  // F(x) = ((S0 + S1) ^ S2) + S3
  assign sum01    = s_data[0] + s_data[1];
  assign f_out    = (sum01 ^ s_data[2]) + s_data[3];
  assign xr_mixed = xr ^ f_out;

endmodule

### dv/blowfish_block_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for blowfish_block_cipher: table loads, key schedule, encrypt/decrypt,
// chaining, APB registers. Depends on hdl/bf_pkg.sv, the two channel interfaces and the RTL.
module blowfish_block_cipher_tb;
  import bf_pkg::*;

  localparam int ROUNDS        = 16;
  localparam int MAX_KEY_BYTES = 56;
  localparam int TABLE_WORDS   = P_WORDS + S_WORDS;
  localparam int INDEX_MAX     = 2 ** 11 - 1;
  localparam int BLOCK_CYCLES  = 2 * ROUNDS + 4;
  localparam int EXPAND_CYCLES = 8 * (ROUNDS + 2) + ((ROUNDS + 3) / 2 + 512) * BLOCK_CYCLES;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 92;
  localparam int SCRIPT_ROWS   = 26;

  // Request codes the block does not define
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [10:0] index;
    logic [31:0] word_left;
    logic [31:0] word_right;
    logic        first_block;
  } bf_request_t;

  typedef struct {
    logic [2:0]  kind;
    logic [10:0] index;
    logic [31:0] word_left;
    logic [31:0] word_right;
    logic        first_block;
    logic [5:0]  key_length;
    logic        chain_mode;
    logic        typed;
    logic [63:0] block_out;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bf_req_if req_ch ();
  bf_res_if res_ch ();

  blowfish_block_cipher #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the engine state
  logic [31:0] p_words [P_WORDS];
  logic [31:0] s_words [S_WORDS];
  logic [7:0]  key_bytes [MAX_KEY_BYTES];
  logic [63:0] chain_block;
  logic [5:0]  cfg_key_length;
  logic        cfg_chain_mode;

  logic [63:0] expected_blocks [$];
  logic [63:0] due_block;
  logic [2:0]  last_kind = REQ_LOAD_WORD;
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          expands_left = 8;
  int          hold_requests = 0;

  // Directed table; tables hold only zeros up to the first nonzero table load, so a block just swaps
  // halves there and the chained rows can be worked out by hand.
  script_row_t script [SCRIPT_ROWS] = '{
    '{REQ_ENCRYPT,   11'd0, 32'h0, 32'h0, 1'b1, 6'd56, 1'b0, 1'b1, 64'h0},
    '{REQ_ENCRYPT,   11'd3, 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd56, 1'b0, 1'b1,
      64'h0000_0000_FFFF_FFFF},
    '{REQ_DECRYPT,   11'd0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 6'd56, 1'b0, 1'b1,
      64'h9ABC_DEF0_1234_5678},
    '{REQ_DECRYPT,   11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 6'd56, 1'b0, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFF},
    '{REQ_SPARE_LO,  11'd0, 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd56, 1'b0, 1'b0, 64'h0},
    '{REQ_SPARE_HI,  11'h7FF, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'd56, 1'b0, 1'b0, 64'h0},
    '{REQ_LOAD_WORD, 11'(INDEX_MAX), 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd56, 1'b0, 1'b0, 64'h0},
    '{REQ_LOAD_WORD, 11'(TABLE_WORDS), 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd56, 1'b0, 1'b0, 64'h0},
    '{REQ_LOAD_KEY,  11'(MAX_KEY_BYTES), 32'hFF, 32'h0, 1'b0, 6'd56, 1'b0, 1'b0, 64'h0},
    '{REQ_LOAD_KEY,  11'(INDEX_MAX), 32'hFF, 32'h0, 1'b0, 6'd56, 1'b0, 1'b0, 64'h0},
    '{REQ_ENCRYPT,   11'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 6'd56, 1'b0, 1'b1,
      64'hF0F0_F0F0_0F0F_0F0F},
    '{REQ_ENCRYPT,   11'd0, 32'h1, 32'h2, 1'b1, 6'd56, 1'b1, 1'b1, 64'h0000_0002_0000_0001},
    '{REQ_ENCRYPT,   11'd0, 32'h0, 32'h0, 1'b0, 6'd56, 1'b1, 1'b1, 64'h0000_0001_0000_0002},
    '{REQ_DECRYPT,   11'd0, 32'h5, 32'h6, 1'b0, 6'd56, 1'b1, 1'b1, 64'h0000_0007_0000_0007},
    '{REQ_DECRYPT,   11'd0, 32'hA, 32'hB, 1'b1, 6'd56, 1'b1, 1'b1, 64'h0000_000B_0000_000A},
    '{REQ_LOAD_WORD, 11'd0, 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd56, 1'b1, 1'b0, 64'h0},
    '{REQ_LOAD_WORD, 11'(P_WORDS - 1), 32'h8000_0001, 32'h0, 1'b0, 6'd56, 1'b1, 1'b0, 64'h0},
    '{REQ_LOAD_WORD, 11'(P_WORDS), 32'h7FFF_FFFE, 32'h0, 1'b0, 6'd56, 1'b1, 1'b0, 64'h0},
    '{REQ_LOAD_WORD, 11'(TABLE_WORDS - 1), 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd56, 1'b1, 1'b0,
      64'h0},
    '{REQ_ENCRYPT,   11'd0, 32'hDEAD_BEEF, 32'h0123_4567, 1'b0, 6'd56, 1'b1, 1'b0, 64'h0},
    '{REQ_LOAD_KEY,  11'd0, 32'hFFFF_FF5A, 32'h0, 1'b0, 6'd56, 1'b1, 1'b0, 64'h0},
    '{REQ_LOAD_KEY,  11'(MAX_KEY_BYTES - 1), 32'hA5, 32'h0, 1'b1, 6'd56, 1'b1, 1'b0, 64'h0},
    '{REQ_EXPAND,    11'd0, 32'h0, 32'h0, 1'b0, 6'd0, 1'b0, 1'b0, 64'h0},
    '{REQ_ENCRYPT,   11'd0, 32'h0, 32'h0, 1'b1, 6'd0, 1'b0, 1'b0, 64'h0},
    '{REQ_EXPAND,    11'd0, 32'h0, 32'h0, 1'b0, 6'd63, 1'b0, 1'b0, 64'h0},
    '{REQ_DECRYPT,   11'd0, 32'hFFFF_FFFF, 32'h0, 1'b0, 6'd63, 1'b0, 1'b0, 64'h0}
  };

  // Round function: four S-box lookups, add / xor / add
  function automatic logic [31:0] mix_f(logic [31:0] x);
    return ((s_words[x[31:24]] + s_words[256 + x[23:16]]) ^ s_words[512 + x[15:8]])
           + s_words[768 + x[7:0]];
  endfunction

  function automatic logic [63:0] encipher_block(logic [63:0] blk);
    logic [31:0] xl, xr, t;
    xl = blk[63:32];
    xr = blk[31:0];
    for (int i = 0; i < ROUNDS; i++) begin
      xl ^= p_words[i];
      xr ^= mix_f(xl);
      t = xl; xl = xr; xr = t;
    end
    // undo the last swap, then whiten
    return {xr ^ p_words[ROUNDS + 1], xl ^ p_words[ROUNDS]};
  endfunction

  function automatic logic [63:0] decipher_block(logic [63:0] blk);
    logic [31:0] xl, xr, t;
    xl = blk[63:32];
    xr = blk[31:0];
    for (int i = ROUNDS + 1; i > 1; i--) begin
      xl ^= p_words[i];
      xr ^= mix_f(xl);
      t = xl; xl = xr; xr = t;
    end
    return {xr ^ p_words[0], xl ^ p_words[1]};
  endfunction

  // Key schedule: fold key bytes into P, then refill P and S from a running block
  function automatic void run_key_schedule();
    int          len;
    int          j;
    logic [31:0] word;
    logic [63:0] blk;
    len = cfg_key_length;
    if (len < 1) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    j = 0;
    for (int i = 0; i < ROUNDS + 2; i++) begin
      word = '0;
      for (int k = 0; k < 4; k++) begin
        word = {word[23:0], key_bytes[j]};
        j++;
        if (j >= len) j = 0;
      end
      p_words[i] ^= word;
    end
    blk = '0;
    for (int i = 0; i < ROUNDS + 2; i += 2) begin
      blk = encipher_block(blk);
      p_words[i] = blk[63:32];
      if (i + 1 < P_WORDS) p_words[i + 1] = blk[31:0];
    end
    for (int i = 0; i < S_WORDS; i += 2) begin
      blk = encipher_block(blk);
      s_words[i]     = blk[63:32];
      s_words[i + 1] = blk[31:0];
    end
  endfunction

  // Update the mirror for one accepted request; return 1 with the block when one comes back
  function automatic bit apply_request(input bf_request_t r, output logic [63:0] blk);
    logic chained;
    chained = cfg_chain_mode && !r.first_block;
    blk = '0;
    case (r.kind)
      REQ_LOAD_WORD: begin
        if (r.index < P_WORDS) p_words[r.index] = r.word_left;
        else if (r.index < TABLE_WORDS) s_words[r.index - P_WORDS] = r.word_left;
      end
      REQ_LOAD_KEY: begin
        if (r.index < MAX_KEY_BYTES) key_bytes[r.index] = r.word_left[7:0];
      end
      REQ_EXPAND: run_key_schedule();
      REQ_ENCRYPT: begin
        blk = {r.word_left, r.word_right};
        if (chained) blk ^= chain_block;
        blk = encipher_block(blk);
        chain_block = blk;
        return 1'b1;
      end
      REQ_DECRYPT: begin
        blk = decipher_block({r.word_left, r.word_right});
        if (chained) blk ^= chain_block;
        chain_block = {r.word_left, r.word_right};
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Offer one request from the falling edge and hold it until the transfer
  task automatic send_request(input bf_request_t r, input bit typed, input logic [63:0] fixed);
    logic [63:0] blk;
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.index       <= r.index;
    req_ch.word_left   <= r.word_left;
    req_ch.word_right  <= r.word_right;
    req_ch.first_block <= r.first_block;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (apply_request(r, blk)) expected_blocks.push_back(typed ? fixed : blk);
    last_kind = r.kind;
  endtask

  // Drop valid for a pause when n is positive
  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Send in bursts of random length, with a random gap before most bursts
  task automatic offer(input bf_request_t r, input bit typed, input logic [63:0] fixed);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
    burst_left--;
    send_request(r, typed, fixed);
  endtask

  // Wait until every block has come back; optionally let a running schedule finish too
  task automatic settle(bit full);
    pause(1);
    while (expected_blocks.size() != 0) @(posedge clk);
    if (full) begin
      if (last_kind == REQ_EXPAND) repeat (EXPAND_CYCLES + EXPAND_CYCLES / 4) @(posedge clk);
      else repeat (2 * BLOCK_CYCLES) @(posedge clk);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both registers with junk in the unused bits, then read them back
  task automatic configure(logic [5:0] kl, logic ch);
    logic [31:0] junk;
    logic [31:0] rd;
    junk = $urandom;
    apb_write({REG_KEY_LENGTH, 2'b00}, {junk[31:6], kl});
    apb_write({REG_CHAIN_MODE, 2'b00}, {junk[31:1], ch});
    apb_read({REG_KEY_LENGTH, 2'b00}, rd);
    if (rd !== {26'b0, kl}) begin
      $display("%0t: key_length read expected %h got %h", $time, {26'b0, kl}, rd);
      error_count++;
    end
    apb_read({REG_CHAIN_MODE, 2'b00}, rd);
    if (rd !== {31'b0, ch}) begin
      $display("%0t: chain_mode read expected %h got %h", $time, {31'b0, ch}, rd);
      error_count++;
    end
    cfg_key_length = kl;
    cfg_chain_mode = ch;
  endtask

  // Mostly encrypt/decrypt with random content; loads, rare schedules, undefined codes
  function automatic bf_request_t random_request();
    bf_request_t r;
    int          pick;
    pick          = $urandom_range(0, 99);
    r.kind        = REQ_ENCRYPT;
    r.index       = 11'($urandom);
    r.word_left   = $urandom;
    r.word_right  = $urandom;
    r.first_block = ($urandom_range(0, 3) == 0);
    if (pick < 10) begin
      r.kind  = REQ_LOAD_WORD;
      r.index = ($urandom_range(0, 7) == 0) ? $urandom_range(TABLE_WORDS, INDEX_MAX)
                                             : $urandom_range(0, TABLE_WORDS - 1);
    end else if (pick < 16) begin
      r.kind  = REQ_LOAD_KEY;
      r.index = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_KEY_BYTES, INDEX_MAX)
                                             : $urandom_range(0, MAX_KEY_BYTES - 1);
    end else if (pick < 18 && expands_left > 0) begin
      r.kind = REQ_EXPAND;
      expands_left--;
    end else if (pick < 21) begin
      r.kind = $urandom_range(REQ_SPARE_LO, REQ_SPARE_HI);
    end else begin
      r.kind = pick[0] ? REQ_ENCRYPT : REQ_DECRYPT;
      if ($urandom_range(0, 15) == 0) r.word_left = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 15) == 0) r.word_right = $urandom_range(0, 1) ? '1 : '0;
    end
    return r;
  endfunction

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL blowfish_block_cipher");
      $finish;
    end
  end

  // Check each result transfer against the oldest expected block
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, res_ch.result_left, res_ch.result_right);
        error_count++;
      end else begin
        due_block = expected_blocks.pop_front();
        if (res_ch.result_left !== due_block[63:32] || res_ch.result_right !== due_block[31:0])
        begin
          $display("%0t: result expected left %h right %h, got left %h right %h", $time,
                   due_block[63:32], due_block[31:0], res_ch.result_left, res_ch.result_right);
          error_count++;
        end
      end
    end
  end

  // Result side: stretches of steady, light and heavy stalling, plus long hold-offs on request
  initial begin
    int stretch;
    int mode;
    int holds_served;
    holds_served = 0;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_served != hold_requests) begin
        holds_served++;
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end
      stretch = $urandom_range(10, 80);
      mode    = $urandom_range(0, 2);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    bf_request_t r;
    logic [31:0] rd;
    logic [5:0]  kl;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_LOAD_WORD;
    req_ch.index       = '0;
    req_ch.word_left   = '0;
    req_ch.word_right  = '0;
    req_ch.first_block = 1'b0;
    chain_block        = '0;
    cfg_key_length     = KEY_LENGTH_RESET;
    cfg_chain_mode     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers come out of reset at their defaults
    apb_read({REG_KEY_LENGTH, 2'b00}, rd);
    if (rd !== {26'b0, KEY_LENGTH_RESET}) begin
      $display("%0t: key_length reset expected %h got %h", $time, {26'b0, KEY_LENGTH_RESET}, rd);
      error_count++;
    end
    apb_read({REG_CHAIN_MODE, 2'b00}, rd);
    if (rd !== 32'h0) begin
      $display("%0t: chain_mode reset expected %h got %h", $time, 32'h0, rd);
      error_count++;
    end

    // Clear every table word and fill the key store before anything reads them
    for (int i = 0; i < TABLE_WORDS; i++) begin
      r = '{REQ_LOAD_WORD, 11'(i), 32'h0, $urandom, 1'($urandom)};
      offer(r, 1'b0, '0);
    end
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      r = '{REQ_LOAD_KEY, 11'(i), $urandom, $urandom, 1'($urandom)};
      offer(r, 1'b0, '0);
    end

    // Directed rows; reconfigure only once the block is idle
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].key_length != cfg_key_length || script[i].chain_mode != cfg_chain_mode)
      begin
        settle(1'b1);
        configure(script[i].key_length, script[i].chain_mode);
      end
      r = '{script[i].kind, script[i].index, script[i].word_left, script[i].word_right,
            script[i].first_block};
      offer(r, script[i].typed, script[i].block_out);
    end

    // Random phases over a spread of register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       kl = 6'd56;
        1:       kl = 6'd1;
        2:       kl = 6'd63;
        3:       kl = 6'd0;
        4:       kl = $urandom_range(2, 55);
        default: kl = 6'd8;
      endcase
      settle(1'b1);
      configure(kl, ph[0] ? 1'b1 : ($urandom_range(0, 3) == 0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the result side for a long stretch while requests keep coming
        if (ph == 1 && n == 20) hold_requests++;
        // hold requests until every block is back
        if (ph == 3 && n == 40) settle(1'b0);
        offer(random_request(), 1'b0, '0);
      end
    end

    settle(1'b1);
    if (error_count == 0) begin
      $display("PASS blowfish_block_cipher");
    end else begin
      $display("FAIL blowfish_block_cipher");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bf_pkg.sv
hdl/bf_req_if.sv
hdl/bf_res_if.sv
hdl/bf_sbox_ram.sv
hdl/bf_feistel.sv
hdl/blowfish_block_cipher.sv
dv/blowfish_block_cipher_tb.sv
